// ===== rtl/core/mwvc_pkg.sv =====
// ----------------------------------------------------------------------------
// mwvc_pkg
// Types and constants shared by the mecanum wheel velocity controller.
// ----------------------------------------------------------------------------
package mwvc_pkg;

  localparam int WHEEL_CNT  = 4;
  localparam int DATA_W     = 24;   // signed Q8.16 payload
  localparam int CFG_W      = 23;   // widest configuration register
  localparam int CFG_IDX_W  = 3;

  // shared multiplier: A covers the 32 bit integrator, B the unsigned registers
  localparam int OPA_W  = 33;
  localparam int OPB_W  = 24;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int RND_W  = PROD_W + 1 - 16;

  localparam logic signed [DATA_W-1:0] DEADBAND_Q16  = 24'sd5243;   // 0.08
  localparam logic signed [DATA_W-1:0] OPEN_LOOP_Q16 = 24'sd19661;  // 0.30

  localparam logic [21:0] RST_INTEGRAL_GAIN      = 22'd131072;
  localparam logic [22:0] RST_LINEAR_LIMIT       = 23'd98304;
  localparam logic [22:0] RST_ANGULAR_LIMIT      = 23'd98304;
  localparam logic [15:0] RST_RIM_RADIUS         = 16'd6658;
  localparam logic [22:0] RST_INVERSE_RIM_RADIUS = 23'd645039;
  localparam logic [17:0] RST_LEVER_ARM          = 18'd35010;
  localparam logic [22:0] RST_INVERSE_LEVER_ARM  = 23'd122680;
  localparam logic [22:0] RST_DRIVE_LIMIT        = 23'd983040;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTEGRAL_GAIN,
    REG_LINEAR_LIMIT,
    REG_ANGULAR_LIMIT,
    REG_RIM_RADIUS,
    REG_INVERSE_RIM_RADIUS,
    REG_LEVER_ARM,
    REG_INVERSE_LEVER_ARM,
    REG_DRIVE_LIMIT
  } cfg_idx_t;

  // one micro-operation per product on the shared multiplier
  typedef enum logic [2:0] {
    OP_TURN,      // lever arm * wz
    OP_SETPOINT,  // 1/r * wheel combination
    OP_INTEG,     // error * tick
    OP_DRIVE,     // ki * integrator
    OP_RVX,
    OP_RVY,
    OP_RWT,       // r * rotational wheel sum
    OP_RWZ        // previous * 1/L
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_RND,
    S_LOAD
  } seq_state_t;

  typedef struct packed {
    logic       ready;
    logic       mul_go;
    logic       commit;
    logic       load;
    op_t        op;
    logic [1:0] wheel;
  } seq_ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] command_vx;
    logic signed [DATA_W-1:0] command_vy;
    logic signed [DATA_W-1:0] command_wz;
    logic signed [DATA_W-1:0] measured_wheel0;
    logic signed [DATA_W-1:0] measured_wheel1;
    logic signed [DATA_W-1:0] measured_wheel2;
    logic signed [DATA_W-1:0] measured_wheel3;
    logic        [15:0]       tick_seconds;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_wheel0;
    logic signed [DATA_W-1:0] drive_wheel1;
    logic signed [DATA_W-1:0] drive_wheel2;
    logic signed [DATA_W-1:0] drive_wheel3;
    logic signed [DATA_W-1:0] robot_vx;
    logic signed [DATA_W-1:0] robot_vy;
    logic signed [DATA_W-1:0] robot_wz;
  } out_item_t;

endpackage

// ===== rtl/core/mwvc_if.sv =====
// ----------------------------------------------------------------------------
// mwvc_if
// Valid/ready channels for the tick input and the report output.
// ----------------------------------------------------------------------------
interface mwvc_in_if;
  import mwvc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mwvc_out_if;
  import mwvc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mwvc_mul.sv =====
// ----------------------------------------------------------------------------
// mwvc_mul
// Shared signed multiplier with registered product and round-half-up rescale.
// ----------------------------------------------------------------------------
module mwvc_mul (
  input  logic                                clk,
  input  logic                                go,
  input  logic signed [mwvc_pkg::OPA_W-1:0]   a,
  input  logic signed [mwvc_pkg::OPB_W-1:0]   b,
  input  logic                                shift18,
  output logic signed [mwvc_pkg::RND_W-1:0]   rnd
);
  import mwvc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   biased;
  logic signed [PROD_W:0]   shifted;

  always_ff @(posedge clk) begin
    if (go) begin
      prod <= a * b;
    end
  end

  // bias by half an lsb of the result, then floor
  always_comb begin
    if (shift18) begin
      biased  = $signed({prod[PROD_W-1], prod}) + $signed((PROD_W+1)'(1) << 17);
      shifted = biased >>> 18;
    end else begin
      biased  = $signed({prod[PROD_W-1], prod}) + $signed((PROD_W+1)'(1) << 15);
      shifted = biased >>> 16;
    end
  end

  assign rnd = shifted[RND_W-1:0];

endmodule

// ===== rtl/core/mwvc_seq.sv =====
// ----------------------------------------------------------------------------
// mwvc_seq
// Sequencer stepping the micro-operations through the shared multiplier.
// ----------------------------------------------------------------------------
module mwvc_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_free,
  output mwvc_pkg::seq_ctl_t ctl
);
  import mwvc_pkg::*;

  seq_state_t state, state_next;
  op_t        op, op_next;
  logic [1:0] wheel, wheel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_TURN;
      wheel <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      wheel <= wheel_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    wheel_next = wheel;
    ctl        = '0;
    ctl.op     = op;
    ctl.wheel  = wheel;
    unique case (state)
      S_IDLE: begin
        ctl.ready = 1'b1;
        if (in_valid) begin
          state_next = S_MUL;
          op_next    = OP_TURN;
          wheel_next = '0;
        end
      end
      S_MUL: begin
        ctl.mul_go = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        ctl.commit = 1'b1;
        state_next = S_MUL;
        unique case (op)
          OP_TURN:     op_next = OP_SETPOINT;
          OP_SETPOINT: op_next = OP_INTEG;
          OP_INTEG:    op_next = OP_DRIVE;
          OP_DRIVE: begin
            if (wheel == 2'(WHEEL_CNT - 1)) begin
              op_next = OP_RVX;
            end else begin
              op_next    = OP_SETPOINT;
              wheel_next = wheel + 2'd1;
            end
          end
          OP_RVX:      op_next = OP_RVY;
          OP_RVY:      op_next = OP_RWT;
          OP_RWT:      op_next = OP_RWZ;
          OP_RWZ:      state_next = S_LOAD;
          default:     op_next = OP_TURN;
        endcase
      end
      S_LOAD: begin
        if (out_free) begin
          ctl.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/mecanum_wheel_velocity_controller.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_velocity_controller
// Mecanum kinematics and per-wheel integral control on one shared multiplier.
// ----------------------------------------------------------------------------
// Schedule: each input transaction runs 17 products on the shared 33x24 multiplier,
//   each a multiply step (S_MUL) and a write-back step (S_RND), then a load (S_LOAD).
// Handshake: tick.ready is low while a tick is being worked through. A finished
//   report waits in its own register, and the load stalls while one is pending.
// Reset (rst, synchronous): registers to their defaults, integrators and last
//   drives to zero, no report pending.
// ----------------------------------------------------------------------------
module mecanum_wheel_velocity_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  mwvc_pkg::cfg_idx_t                 cfg_index,
  input  logic [mwvc_pkg::CFG_W-1:0]         cfg_data,
  mwvc_in_if.sink                            tick,
  mwvc_out_if.source                         report
);
  import mwvc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [21:0] integral_gain;
  logic [22:0] linear_limit;
  logic [22:0] angular_limit;
  logic [15:0] rim_radius;
  logic [22:0] inverse_rim_radius;
  logic [17:0] lever_arm;
  logic [22:0] inverse_lever_arm;
  logic [22:0] drive_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_gain      <= RST_INTEGRAL_GAIN;
      linear_limit       <= RST_LINEAR_LIMIT;
      angular_limit      <= RST_ANGULAR_LIMIT;
      rim_radius         <= RST_RIM_RADIUS;
      inverse_rim_radius <= RST_INVERSE_RIM_RADIUS;
      lever_arm          <= RST_LEVER_ARM;
      inverse_lever_arm  <= RST_INVERSE_LEVER_ARM;
      drive_limit        <= RST_DRIVE_LIMIT;
    end else if (cfg_write) begin
      // upper data bits beyond a register's width are dropped
      unique case (cfg_index)
        REG_INTEGRAL_GAIN:      integral_gain      <= cfg_data[21:0];
        REG_LINEAR_LIMIT:       linear_limit       <= cfg_data[22:0];
        REG_ANGULAR_LIMIT:      angular_limit      <= cfg_data[22:0];
        REG_RIM_RADIUS:         rim_radius         <= cfg_data[15:0];
        REG_INVERSE_RIM_RADIUS: inverse_rim_radius <= cfg_data[22:0];
        REG_LEVER_ARM:          lever_arm          <= cfg_data[17:0];
        REG_INVERSE_LEVER_ARM:  inverse_lever_arm  <= cfg_data[22:0];
        REG_DRIVE_LIMIT:        drive_limit        <= cfg_data[22:0];
        default:                drive_limit        <= drive_limit;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // symmetric clamp of a command to +/- limit
  function automatic logic signed [DATA_W-1:0] clamp_cmd(
    input logic signed [DATA_W-1:0] x,
    input logic [22:0]              lim
  );
    logic signed [DATA_W:0] hi;
    logic signed [DATA_W:0] lo;
    logic signed [DATA_W:0] xe;
    hi = $signed({2'b00, lim});
    lo = -hi;
    xe = $signed({x[DATA_W-1], x});
    if (xe > hi) begin
      return hi[DATA_W-1:0];
    end else if (xe < lo) begin
      return lo[DATA_W-1:0];
    end
    return x;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [RND_W-1:0] x);
    if (x > $signed(RND_W'(24'sh7FFFFF))) begin
      return 24'sh7FFFFF;
    end else if (x < -$signed(RND_W'(24'sh7FFFFF)) - RND_W'(1)) begin
      return 24'sh800000;
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RND_W:0] x);
    if (x > $signed((RND_W+1)'(32'sh7FFFFFFF))) begin
      return 32'sh7FFFFFFF;
    end else if (x < -$signed((RND_W+1)'(32'sh7FFFFFFF)) - (RND_W+1)'(1)) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer and shared multiplier
  // --------------------------------------------------------------------------
  seq_ctl_t ctl;
  logic     out_free;

  assign out_free = !report.valid || report.ready;

  mwvc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  assign tick.ready = ctl.ready;

  logic signed [OPA_W-1:0] mul_a;
  logic signed [OPB_W-1:0] mul_b;
  logic                    mul_shift18;
  logic signed [RND_W-1:0] rnd;

  mwvc_mul u_mul (
    .clk     (clk),
    .go      (ctl.mul_go),
    .a       (mul_a),
    .b       (mul_b),
    .shift18 (mul_shift18),
    .rnd     (rnd)
  );

  // --------------------------------------------------------------------------
  // Tick capture: commands are clamped on the way in
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] vx, vy, wz;
  logic signed [DATA_W-1:0] meas [WHEEL_CNT];
  logic        [15:0]       dt;

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      vx      <= clamp_cmd(tick.payload.command_vx, linear_limit);
      vy      <= clamp_cmd(tick.payload.command_vy, linear_limit);
      wz      <= clamp_cmd(tick.payload.command_wz, angular_limit);
      meas[0] <= tick.payload.measured_wheel0;
      meas[1] <= tick.payload.measured_wheel1;
      meas[2] <= tick.payload.measured_wheel2;
      meas[3] <= tick.payload.measured_wheel3;
      dt      <= tick.payload.tick_seconds;
    end
  end

  // --------------------------------------------------------------------------
  // Working registers and controller state
  // --------------------------------------------------------------------------
  logic signed [26:0]       turn;       // L*wz, later r*rotational sum
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] robot_vx, robot_vy, robot_wz;
  logic signed [31:0]       integ      [WHEEL_CNT];
  logic signed [DATA_W-1:0] last_drive [WHEEL_CNT];

  // --------------------------------------------------------------------------
  // Per-wheel operands
  // --------------------------------------------------------------------------
  logic signed [27:0]       wheel_mix;   // vx +/- vy +/- turn
  logic signed [DATA_W-1:0] meas_sel;
  logic signed [DATA_W-1:0] meas_filt;
  logic signed [DATA_W-1:0] drive_sel;
  logic                     open_loop;
  logic signed [DATA_W:0]   err;
  logic signed [25:0]       sum_x, sum_y, sum_w;

  always_comb begin
    logic signed [27:0] ex, ey, et;
    ex = 28'(vx);
    ey = 28'(vy);
    et = 28'(turn);
    unique case (ctl.wheel)
      2'd0:    wheel_mix = ex - ey - et;
      2'd1:    wheel_mix = ex + ey + et;
      2'd2:    wheel_mix = ex + ey - et;
      default: wheel_mix = ex - ey + et;
    endcase
  end

  assign meas_sel  = meas[ctl.wheel];
  assign drive_sel = last_drive[ctl.wheel];

  // slow wheels read as standing still
  assign meas_filt = (meas_sel > -DEADBAND_Q16 && meas_sel < DEADBAND_Q16) ? '0 : meas_sel;

  // near standstill the loop runs against the last drive rather than the encoder
  assign open_loop = (setpoint > -OPEN_LOOP_Q16 && setpoint < OPEN_LOOP_Q16) &&
                     (drive_sel > -OPEN_LOOP_Q16 && drive_sel < OPEN_LOOP_Q16);

  assign err = (DATA_W+1)'(setpoint) - (DATA_W+1)'(open_loop ? drive_sel : meas_filt);

  // forward kinematics sums on the raw wheel speeds
  assign sum_x = 26'(meas[0]) + 26'(meas[1]) + 26'(meas[2]) + 26'(meas[3]);
  assign sum_y = 26'(meas[1]) + 26'(meas[2]) - 26'(meas[0]) - 26'(meas[3]);
  assign sum_w = 26'(meas[1]) + 26'(meas[3]) - 26'(meas[0]) - 26'(meas[2]);

  // operand select for the shared multiplier
  always_comb begin
    mul_shift18 = 1'b0;
    unique case (ctl.op)
      OP_TURN: begin
        mul_a = OPA_W'(wz);
        mul_b = $signed({6'b0, lever_arm});
      end
      OP_SETPOINT: begin
        mul_a = OPA_W'(wheel_mix);
        mul_b = $signed({1'b0, inverse_rim_radius});
      end
      OP_INTEG: begin
        mul_a = OPA_W'(err);
        mul_b = $signed({8'b0, dt});
      end
      OP_DRIVE: begin
        mul_a = OPA_W'(integ[ctl.wheel]);
        mul_b = $signed({2'b0, integral_gain});
      end
      OP_RVX: begin
        mul_a       = OPA_W'(sum_x);
        mul_b       = $signed({8'b0, rim_radius});
        mul_shift18 = 1'b1;
      end
      OP_RVY: begin
        mul_a       = OPA_W'(sum_y);
        mul_b       = $signed({8'b0, rim_radius});
        mul_shift18 = 1'b1;
      end
      OP_RWT: begin
        mul_a = OPA_W'(sum_w);
        mul_b = $signed({8'b0, rim_radius});
      end
      OP_RWZ: begin
        mul_a       = OPA_W'(turn);
        mul_b       = $signed({1'b0, inverse_lever_arm});
        mul_shift18 = 1'b1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Write-back of each rounded product
  // --------------------------------------------------------------------------
  logic signed [RND_W:0]    integ_sum;
  logic signed [RND_W-1:0]  lim_w;
  logic signed [DATA_W-1:0] drive_new;

  assign integ_sum = (RND_W+1)'(integ[ctl.wheel]) + (RND_W+1)'(rnd);
  assign lim_w     = $signed(RND_W'(drive_limit));

  always_comb begin
    if (rnd > lim_w) begin
      drive_new = DATA_W'(lim_w);
    end else if (rnd < -lim_w) begin
      drive_new = DATA_W'(-lim_w);
    end else begin
      drive_new = DATA_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEEL_CNT; i++) begin
        integ[i]      <= '0;
        last_drive[i] <= '0;
      end
    end else if (ctl.commit) begin
      if (ctl.op == OP_INTEG) begin
        integ[ctl.wheel] <= sat32(integ_sum);
      end
      if (ctl.op == OP_DRIVE) begin
        last_drive[ctl.wheel] <= drive_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      unique case (ctl.op)
        OP_TURN:     turn     <= rnd[26:0];
        OP_SETPOINT: setpoint <= sat24(rnd);
        OP_RVX:      robot_vx <= sat24(rnd);
        OP_RVY:      robot_vy <= sat24(rnd);
        OP_RWT:      turn     <= rnd[26:0];
        OP_RWZ:      robot_wz <= sat24(rnd);
        default:     turn     <= turn;   // integrator and drive handled above
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Report register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (ctl.load) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      report.payload.drive_wheel0 <= last_drive[0];
      report.payload.drive_wheel1 <= last_drive[1];
      report.payload.drive_wheel2 <= last_drive[2];
      report.payload.drive_wheel3 <= last_drive[3];
      report.payload.robot_vx     <= robot_vx;
      report.payload.robot_vy     <= robot_vy;
      report.payload.robot_wz     <= robot_wz;
    end
  end

`ifndef SYNTHESIS
  // a pending report is never overwritten
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> (!report.valid || report.ready))
    else $error("report register overwritten");

  // once a tick transaction is taken the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> !tick.ready)
    else $error("tick accepted twice in a row");

  // every write-back uses a product formed in the previous cycle
  a_commit_after_mul: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> $past(ctl.mul_go))
    else $error("write-back without a fresh product");

  // a report only appears after the sequencer has loaded it
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(report.valid) |-> $past(ctl.load))
    else $error("report valid without load");
`endif

endmodule
